### src/error_code_blinker_assert.svh
// Assertion macros used by the blinker core RTL.
`ifndef ERROR_CODE_BLINKER_ASSERT_SVH
`define ERROR_CODE_BLINKER_ASSERT_SVH

`ifndef SYNTHESIS
`define ECB_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ecb assertion failed");
`define ECB_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("ecb assertion failed");
`else
`define ECB_ASSERT(name, clk, rst, prop)
`define ECB_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

### src/ecb_pkg.sv
package ecb_pkg;

   localparam int CODE_W     = 4;
   localparam int ERR_CODE_W = 8;
   localparam int CMD_W      = 2;
   localparam int CFG_W      = 16;
   localparam int BITMAP_W   = 8;
   localparam int RSP_DATA_W = 16;
   localparam int REQ_DATA_W = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_FLAG  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   localparam logic REG_TICK_PERIOD = 1'b0;
   localparam logic REG_BLINK_ON    = 1'b1;

   localparam logic [CFG_W-1:0] TICK_PERIOD_RESET = 16'd500;
   localparam logic [CFG_W-1:0] BLINK_ON_RESET    = 16'd200;

   typedef struct packed {
      logic [CFG_W-1:0] tick_period_ms;
      logic [CFG_W-1:0] blink_on_ms;
   } cfg_type;

   typedef struct packed {
      logic                  valid;
      logic [CMD_W-1:0]      cmd;
      logic [ERR_CODE_W-1:0] error_code;
   } req_type;

endpackage

### src/ecb_csr.sv
module ecb_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic                       csr_addr,
   input  logic [ecb_pkg::CFG_W-1:0]  csr_wdata,
   output ecb_pkg::cfg_type           cfg
);
   import ecb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_TICK_PERIOD: cfg_in.tick_period_ms = csr_wdata;
            REG_BLINK_ON:    cfg_in.blink_on_ms    = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_period_ms <= TICK_PERIOD_RESET;
         cfg_ff.blink_on_ms    <= BLINK_ON_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/ecb_in_stage.sv
module ecb_in_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ecb_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [ecb_pkg::CMD_W-1:0]      req_tuser,
   input  logic                           advance,
   output ecb_pkg::req_type               req
);
   import ecb_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [CMD_W-1:0]      cmd_ff;
   logic [ERR_CODE_W-1:0] code_ff;
   logic                  take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      priority if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff  <= req_tuser;
         code_ff <= req_tdata[ERR_CODE_W-1:0];
      end
   end

   assign req.valid      = valid_ff;
   assign req.cmd        = cmd_ff;
   assign req.error_code = code_ff;

endmodule

### src/ecb_core.sv
`include "error_code_blinker_assert.svh"

module ecb_core #(
   parameter int NUM_CODES = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ecb_pkg::cfg_type               cfg,
   input  ecb_pkg::req_type               req,
   output logic                           advance,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ecb_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ecb_pkg::*;

   localparam logic [CODE_W-1:0]     LAST_CODE = CODE_W'(NUM_CODES);
   localparam logic [ERR_CODE_W-1:0] LAST_ERR  = ERR_CODE_W'(NUM_CODES);

   logic [NUM_CODES-1:0] flags_ff, flags_in;
   logic [CFG_W-1:0]     elapsed_ff, elapsed_in;
   logic [CODE_W-1:0]    index_ff, index_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic                 led_ff, led_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                 fire;
   logic [CFG_W-1:0]     elapsed_inc;
   logic [CODE_W-1:0]    index_inc;
   logic [NUM_CODES+BITMAP_W-1:0] flags_ext;

   // round-robin: first set code after cur, wrapping; 0 if none
   function automatic logic [CODE_W-1:0] pick_next(input logic [CODE_W-1:0] cur,
                                                   input logic [NUM_CODES-1:0] flags);
      logic [CODE_W:0]      c;
      logic [NUM_CODES-1:0] sh;
      logic                 found;
      logic [CODE_W-1:0]    res;
      found = 1'b0;
      res   = '0;
      for (int k = 1; k <= NUM_CODES; k++) begin
         c = {1'b0, cur} + (CODE_W+1)'(k);
         if (c > (CODE_W+1)'(NUM_CODES)) begin
            c = c - (CODE_W+1)'(NUM_CODES);
         end
         sh = flags >> (c - 1'b1);
         if (!found && c != '0 && c <= (CODE_W+1)'(NUM_CODES) && sh[0]) begin
            found = 1'b1;
            res   = c[CODE_W-1:0];
         end
      end
      return res;
   endfunction

   assign advance = !rsp_valid_ff || rsp_tready;
   assign fire    = req.valid && advance;

   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign index_inc   = index_ff + 1'b1;

   always_comb begin
      flags_in   = flags_ff;
      elapsed_in = elapsed_ff;
      index_in   = index_ff;
      code_in    = code_ff;
      led_in     = led_ff;
      unique case (req.cmd)
         CMD_TICK: begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc >= cfg.tick_period_ms) begin
               index_in = index_inc;
               if (index_inc >= LAST_CODE) begin
                  index_in = '0;
                  code_in  = pick_next(code_ff, flags_ff);
               end
               if (index_in < code_in) begin
                  led_in = 1'b1;
               end
               elapsed_in = '0;
            end else if (elapsed_inc >= cfg.blink_on_ms) begin
               led_in = 1'b0;
            end
         end
         CMD_FLAG: begin
            if (req.error_code != '0 && req.error_code <= LAST_ERR) begin
               if (req.error_code == LAST_ERR) begin
                  flags_in = '0;
               end
               flags_in = flags_in | (NUM_CODES'(1) << (req.error_code - 1'b1));
            end
         end
         CMD_CLEAR: flags_in = '0;
         default:   flags_in = flags_ff;
      endcase
   end

   assign flags_ext    = {{BITMAP_W{1'b0}}, flags_in};
   assign rsp_data_in  = {{(RSP_DATA_W-CODE_W-BITMAP_W-1){1'b0}}, code_in,
                          flags_ext[BITMAP_W-1:0], led_in};
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         elapsed_ff   <= '0;
         index_ff     <= '0;
         code_ff      <= '0;
         led_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            flags_ff   <= flags_in;
            elapsed_ff <= elapsed_in;
            index_ff   <= index_in;
            code_ff    <= code_in;
            led_ff     <= led_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ECB_ASSERT(a_index_range, clock, reset, index_ff < LAST_CODE)
   `ECB_ASSERT(a_code_range, clock, reset, code_ff <= LAST_CODE)
   `ECB_ASSERT(a_code_at_wrap, clock, reset, !$stable(code_ff) |-> index_ff == '0)
   `ECB_ASSERT(a_led_on_slot, clock, reset, $rose(led_ff) |-> elapsed_ff == '0)
   `ECB_ASSERT_ALWAYS(a_no_state_without_item, clock,
                      !reset && !$past(fire) && !$past(reset) |-> $stable(elapsed_ff))

endmodule

### src/error_code_blinker.sv
// Error code blinker: latches error codes 1..NUM_CODES (NUM_CODES from 2 to 15) and
// blinks the chosen code on one LED as a count of flashes per cycle of NUM_CODES
// slots. Each req item is a command in req_tuser: a one-millisecond tick, flag the
// code in req_tdata, or clear all flags. The top code is critical and replaces all
// other flags. Every item yields one rsp item carrying the LED level, the low eight
// flag bits and the code being shown; flag changes reach the shown code at the next
// cycle wrap. One item is taken per clock unless rsp_tready stalls the output; an item
// passes an input register and then a result register before its rsp item is valid. The
// round-robin pick over NUM_CODES flags sits in the result stage. csr_addr 0 is
// tick_period_ms (reset 500), 1 is blink_on_ms (reset 200); write them only while idle.
module error_code_blinker #(
   parameter int NUM_CODES = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ecb_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] error_code
   input  logic [ecb_pkg::CMD_W-1:0]      req_tuser,   // [1:0] cmd
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ecb_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [0] led_on, [8:1] active_errors,
                                                       // [12:9] shown_code, rest zero
   input  logic                           csr_we,
   input  logic                           csr_addr,
   input  logic [ecb_pkg::CFG_W-1:0]      csr_wdata
);
   import ecb_pkg::*;

   cfg_type cfg;
   req_type req;
   logic    advance;

   ecb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ecb_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .req        (req)
   );

   ecb_core #(
      .NUM_CODES (NUM_CODES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req        (req),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### bench/tb_error_code_blinker.sv
`timescale 1ns / 1ps

module tb_error_code_blinker;
   import ecb_pkg::*;

   localparam int NUM_CODES = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int MAX_REPORTS = 10;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int IDLE_NONE = 0;
   localparam int IDLE_SEND = 1;
   localparam int IDLE_RECV = 2;
   localparam int IDLE_BOTH = 3;

   typedef struct packed {
      logic [2:0] pad;
      logic [3:0] shown_code;
      logic [7:0] active_errors;
      logic       led_on;
   } blink_rsp_type;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [ERR_CODE_W-1:0] code;
      logic                  fixed;
      blink_rsp_type         rsp;
   } dir_row_type;

   typedef struct packed {
      logic [CFG_W-1:0] period;
      logic [CFG_W-1:0] on_time;
      int               items;
      int               idle_mode;
      logic             pressure;
   } phase_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic                  csr_addr = 1'b0;
   logic [CFG_W-1:0]      csr_wdata = '0;

   // predictor state
   logic [CFG_W-1:0]     period_ms;
   logic [CFG_W-1:0]     on_ms;
   logic [NUM_CODES-1:0] flag_map;
   logic [15:0]          elapsed;
   logic [3:0]           slot;
   logic [3:0]           shown;
   logic                 led;

   blink_rsp_type blink_expect_q[$];
   int            mismatches = 0;
   int            idle_mode = IDLE_NONE;
   bit            pressure_arm = 1'b0;
   bit            pressure_done = 1'b0;
   int            hold_left = 0;
   int            quiet_cycles = 0;

   dir_row_type dir_rows [0:15] = '{
      '{CMD_TICK,   8'h00, 1'b1, '{3'd0, 4'd0, 8'h00, 1'b0}},
      '{CMD_FLAG,   8'h00, 1'b1, '{3'd0, 4'd0, 8'h00, 1'b0}},
      '{CMD_FLAG,   8'h09, 1'b1, '{3'd0, 4'd0, 8'h00, 1'b0}},
      '{CMD_FLAG,   8'hFF, 1'b1, '{3'd0, 4'd0, 8'h00, 1'b0}},
      '{CMD_FLAG,   8'h01, 1'b1, '{3'd0, 4'd0, 8'h01, 1'b0}},
      '{CMD_FLAG,   8'h03, 1'b1, '{3'd0, 4'd0, 8'h05, 1'b0}},
      '{CMD_FLAG,   8'h07, 1'b1, '{3'd0, 4'd0, 8'h45, 1'b0}},
      '{CMD_UNUSED, 8'hAA, 1'b1, '{3'd0, 4'd0, 8'h45, 1'b0}},
      '{CMD_FLAG,   8'h08, 1'b1, '{3'd0, 4'd0, 8'h80, 1'b0}},
      '{CMD_FLAG,   8'h02, 1'b1, '{3'd0, 4'd0, 8'h82, 1'b0}},
      '{CMD_CLEAR,  8'h55, 1'b1, '{3'd0, 4'd0, 8'h00, 1'b0}},
      '{CMD_FLAG,   8'h08, 1'b1, '{3'd0, 4'd0, 8'h80, 1'b0}},
      '{CMD_TICK,   8'hFF, 1'b1, '{3'd0, 4'd0, 8'h80, 1'b0}},
      '{CMD_FLAG,   8'h80, 1'b1, '{3'd0, 4'd0, 8'h80, 1'b0}},
      '{CMD_FLAG,   8'h05, 1'b1, '{3'd0, 4'd0, 8'h90, 1'b0}},
      '{CMD_TICK,   8'h00, 1'b0, '0}
   };

   phase_type phases [0:7] = '{
      '{16'd1,     16'd1,     150, IDLE_NONE, 1'b0},
      '{16'd2,     16'd1,     150, IDLE_SEND, 1'b0},
      '{16'd3,     16'd7,     150, IDLE_RECV, 1'b1},
      '{16'd0,     16'd0,     120, IDLE_BOTH, 1'b0},
      '{16'd4,     16'd2,     150, IDLE_NONE, 1'b0},
      '{16'd65535, 16'd65535, 40,  IDLE_SEND, 1'b0},
      '{16'd1,     16'd65535, 100, IDLE_RECV, 1'b0},
      '{16'd5,     16'd3,     150, IDLE_BOTH, 1'b0}
   };

   error_code_blinker #(.NUM_CODES(NUM_CODES)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] error_code
      .req_tuser  (req_tuser),   // [1:0] cmd
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [0] led_on, [8:1] active_errors, [12:9] shown_code
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [3:0] next_shown_code(input logic [3:0] cur);
      int c;
      for (int k = 1; k <= NUM_CODES; k++) begin
         c = int'(cur) + k;
         if (c > NUM_CODES) c -= NUM_CODES;
         if (flag_map[c-1]) return 4'(c);
      end
      return 4'd0;
   endfunction

   task automatic predict_blinker(input logic [CMD_W-1:0] cmd,
                                  input logic [ERR_CODE_W-1:0] code,
                                  output blink_rsp_type rsp);
      unique case (cmd)
         CMD_TICK: begin
            if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
            if (elapsed >= period_ms) begin
               slot = slot + 4'd1;
               if (slot >= NUM_CODES) begin
                  slot = 4'd0;
                  shown = next_shown_code(shown);
               end
               if (slot < shown) led = 1'b1;
               elapsed = 16'd0;
            end else if (elapsed >= on_ms) begin
               led = 1'b0;
            end
         end
         CMD_FLAG: begin
            if (code >= 1 && code <= NUM_CODES) begin
               if (code == NUM_CODES) flag_map = '0;
               flag_map[code-1] = 1'b1;
            end
         end
         CMD_CLEAR: flag_map = '0;
         default: ;
      endcase
      rsp.pad = 3'd0;
      rsp.shown_code = shown;
      rsp.active_errors = flag_map[7:0];
      rsp.led_on = led;
   endtask

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ERR_CODE_W-1:0] code,
                            input logic fixed, input blink_rsp_type fixed_rsp);
      int            idle_pct;
      blink_rsp_type rsp;
      idle_pct = (idle_mode == IDLE_SEND) ? 52 : (idle_mode == IDLE_BOTH) ? 20 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= code;
      do @(posedge clock); while (!req_tready);
      predict_blinker(cmd, code, rsp);
      blink_expect_q.push_back(fixed ? fixed_rsp : rsp);
   endtask

   task automatic drain_and_write(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] on);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (blink_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= REG_TICK_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      csr_addr <= REG_BLINK_ON;
      csr_wdata <= on;
      @(posedge clock);
      csr_we <= 1'b0;
      period_ms = period;
      on_ms = on;
   endtask

   always @(posedge clock) begin
      int            stall_pct;
      blink_rsp_type got;
      blink_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = blink_rsp_type'(rsp_tdata);
         if (blink_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected rsp item %h", rsp_tdata);
         end else begin
            want = blink_expect_q.pop_front();
            if (got.led_on !== want.led_on || got.active_errors !== want.active_errors ||
                got.shown_code !== want.shown_code || got.pad !== want.pad) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("rsp mismatch: led %b/%b active %h/%h shown %0d/%0d pad %b/%b",
                           want.led_on, got.led_on, want.active_errors, got.active_errors,
                           want.shown_code, got.shown_code, want.pad, got.pad);
            end
         end
      end
      if (pressure_arm && !pressure_done) begin
         hold_left = HOLD_OFF_CYCLES;
         pressure_done = 1'b1;
      end
      stall_pct = (idle_mode == IDLE_RECV) ? 52 : (idle_mode == IDLE_BOTH) ? 20 : 0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("error_code_blinker verification failed");
            $finish;
         end
      end
   end

   initial begin
      logic [CMD_W-1:0]      cmd;
      logic [ERR_CODE_W-1:0] code;
      int                    r;
      period_ms = TICK_PERIOD_RESET;
      on_ms = BLINK_ON_RESET;
      flag_map = '0;
      elapsed = '0;
      slot = '0;
      shown = '0;
      led = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_item(dir_rows[i].cmd, dir_rows[i].code, dir_rows[i].fixed, dir_rows[i].rsp);

      foreach (phases[p]) begin
         drain_and_write(phases[p].period, phases[p].on_time);
         idle_mode = phases[p].idle_mode;
         if (phases[p].pressure) pressure_arm = 1'b1;
         for (int n = 0; n < phases[p].items; n++) begin
            r = $urandom_range(99);
            code = 8'($urandom_range(255));
            if (r < 78) begin
               cmd = CMD_TICK;
            end else if (r < 93) begin
               cmd = CMD_FLAG;
               if ($urandom_range(3) != 0) code = 8'($urandom_range(NUM_CODES, 1));
            end else if (r < 97) begin
               cmd = CMD_CLEAR;
            end else begin
               cmd = CMD_UNUSED;
            end
            send_item(cmd, code, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (blink_expect_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("error_code_blinker verification clean");
      end else begin
         $display("error_code_blinker verification failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/ecb_pkg.sv
src/ecb_csr.sv
src/ecb_in_stage.sv
src/ecb_core.sv
src/error_code_blinker.sv
bench/tb_error_code_blinker.sv
